/* hdl/assert_macros.svh */
// Assertion macros for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, checked on the rising clock edge outside reset.
`define MWLFO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never hold outside reset.
`define MWLFO_NEVER(lbl, clk, rst_n, expr, msg) \
    `MWLFO_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

/* hdl/mwlfo_pkg.sv */
// Package: waveform codes, register indexes and sine table generator.
`timescale 1ns / 1ps

package mwlfo_pkg;

    typedef logic [2:0] t_wave;
    typedef logic [1:0] t_reg_idx;

    localparam t_wave WAVE_SAW      = 3'd0;
    localparam t_wave WAVE_SINE     = 3'd1;
    localparam t_wave WAVE_SQUARE   = 3'd2;
    localparam t_wave WAVE_TRIANGLE = 3'd3;
    localparam t_wave WAVE_STEPPED  = 3'd4;
    localparam t_wave WAVE_SMOOTH   = 3'd5;

    localparam t_reg_idx REG_WAVEFORM    = 2'd0;
    localparam t_reg_idx REG_START_PHASE = 2'd1;
    localparam t_reg_idx REG_PHASE_STEP  = 2'd2;
    localparam t_reg_idx REG_HOLD_LENGTH = 2'd3;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave sine entry in Q2.30, Taylor series to x^11, truncated.
    function automatic logic [30:0] sine_entry(input int unsigned idx,
                                               input int unsigned tbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned p;
        longint unsigned d;
        longint unsigned s;
        x = (longint'(idx) * HALF_PI_Q30) >> tbits;
        x2 = (x * x) >> 30;
        t = Q30_ONE;
        for (int k = 0; k < 5; k++) begin
            p = (x2 * t) >> 30;
            case (k)
                0:       d = p / 110;
                1:       d = p / 72;
                2:       d = p / 42;
                3:       d = p / 20;
                default: d = p / 6;
            endcase
            t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
        end
        s = (x * t) >> 30;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        return s[30:0];
    endfunction

endpackage

/* hdl/multi_waveform_lfo.sv */
// Multi-waveform low-frequency oscillator, top level.
//
// Usage: each input beat on the s_axis channel carries a sample position
// (tdata[31:0]); the block answers with one beat on m_axis carrying the
// level (tdata[15:0], unsigned Q0.16, 65535 = 1.0). Shape, start phase,
// phase step and hold length are written on the cfg channel while idle.
// One item is worked at a time by a small sequencer around one shared
// 32x32 multiplier, a one-bit-per-cycle restoring divider and a one-bit
// LFSR shift step. Work from accept to output valid, by shape:
//   saw, sine, square, triangle: multiply, add, table read, shape
//   stepped random: straight to output while holding, an LFSR draw on a new draw
//   smooth random: multiply, divide and fade while fading (divider runs
//     LEVEL_BITS + 16 steps), an LFSR draw on a new draw, the fade step
//     alone if hold length is zero; unused shape codes output zero.
// A new item can be taken as soon as output valid is shown; a finished
// level may still wait in the output register meanwhile. If the receiver
// stalls, the sequencer waits in its last state until the register frees.
// Reset (synchronous, active low) restores register defaults, clears the
// random state and seeds the LFSR with one; the sine table is constant.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_waveform_lfo
    import mwlfo_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10,
    parameter int LEVEL_BITS      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] position
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] level
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);

    localparam int L      = LEVEL_BITS;
    localparam int B      = SINE_TABLE_BITS;
    localparam int N      = 1 << B;
    localparam int DW     = L + 16;
    localparam int CW     = $clog2(DW);
    localparam int LW     = (L > 16) ? L : 16;
    localparam logic [L-1:0] LMAX = {L{1'b1}};

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_PHASE  = 4'd2;
    localparam logic [3:0] S_ROM    = 4'd3;
    localparam logic [3:0] S_SHAPE  = 4'd4;
    localparam logic [3:0] S_DRAW   = 4'd5;
    localparam logic [3:0] S_FMUL   = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_FADE   = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    logic [3:0]        r_state;
    t_wave             r_waveform;
    logic [31:0]       r_start_phase;
    logic [31:0]       r_phase_step;
    logic [15:0]       r_hold_length;

    logic [15:0]       r_countdown;
    logic [L-1:0]      r_held;
    logic [L-1:0]      r_next;
    logic signed [L:0] r_diff;
    logic [31:0]       r_noise;

    logic [31:0]       r_pos;
    logic [31:0]       r_prod;
    logic [31:0]       r_phase;
    logic [30:0]       r_sine;
    logic [15:0]       r_num;
    logic [DW-1:0]     r_quot;
    logic [16:0]       r_rem;
    logic [CW-1:0]     r_cnt;
    logic [L-1:0]      r_level;
    logic              r_out_valid;
    logic [15:0]       r_out_data;

    logic [30:0]       w_sine_rom [N+1];

    genvar g;
    generate
        for (g = 0; g <= N; g++) begin : g_rom
            localparam logic [30:0] ENTRY = sine_entry(g, B);
            assign w_sine_rom[g] = ENTRY;
        end
    endgenerate

    // shared multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [L:0]  abs_wide;
    logic [L-1:0] abs_diff;

    assign abs_wide = r_diff[L] ? (L+1)'(-r_diff) : (L+1)'(r_diff);
    assign abs_diff = abs_wide[L-1:0];
    assign mul_a    = (r_state == S_FMUL) ? 32'(abs_diff) : r_pos;
    assign mul_b    = (r_state == S_FMUL) ? 32'(r_num) : r_phase_step;
    assign mul_p    = 64'(mul_a) * 64'(mul_b);

    // sine table address with quadrant mirror
    logic [B-1:0] rom_idx;
    logic [B:0]   rom_addr;
    assign rom_idx  = r_phase[29 -: B];
    assign rom_addr = r_phase[30] ? ((B+1)'(N) - {1'b0, rom_idx}) : {1'b0, rom_idx};

    // shape from phase
    logic [31:0]  sine_v;
    logic [31:0]  sine_sh;
    logic [32:0]  tri_v;
    logic [32:0]  tri_sh;
    logic [L-1:0] shape_level;

    assign sine_v  = r_phase[31] ? (32'(Q30_ONE) - 32'(r_sine)) : (32'(Q30_ONE) + 32'(r_sine));
    assign sine_sh = sine_v >> (31 - L);
    assign tri_v   = r_phase[31] ? (33'h1_0000_0000 - 33'(r_phase)) : 33'(r_phase);
    assign tri_sh  = tri_v >> (31 - L);

    always_comb begin
        shape_level = '0;
        case (r_waveform)
            WAVE_SAW:      shape_level = r_phase[31 -: L];
            WAVE_SINE:     shape_level = (sine_sh > 32'(LMAX)) ? LMAX : sine_sh[L-1:0];
            WAVE_SQUARE:   shape_level = r_phase[31] ? LMAX : '0;
            WAVE_TRIANGLE: shape_level = (tri_sh > 33'(LMAX)) ? LMAX : tri_sh[L-1:0];
            default:       shape_level = '0;
        endcase
    end

    // LFSR step, taps 32,22,2,1
    logic [31:0] n_noise;
    assign n_noise = {r_noise[30:0], r_noise[31] ^ r_noise[21] ^ r_noise[1] ^ r_noise[0]};

    // divider step
    logic [16:0] rem_sh;
    logic        rem_ge;
    assign rem_sh = {r_rem[15:0], r_quot[DW-1]};
    assign rem_ge = rem_sh >= {1'b0, r_hold_length};

    // fade result
    logic [L-1:0] mag;
    logic [L:0]   fade_sum;
    logic [L-1:0] fade_level;
    assign mag      = r_quot[L-1:0];
    assign fade_sum = {1'b0, r_held} + {1'b0, mag};
    always_comb begin
        if (r_diff[L]) begin
            fade_level = (mag > r_held) ? '0 : r_held - mag;
        end else begin
            fade_level = fade_sum[L] ? LMAX : fade_sum[L-1:0];
        end
    end

    logic [15:0]  n_countdown;
    logic [LW-1:0] level_ext;
    assign n_countdown = r_countdown - 16'd1;
    assign level_ext   = LW'(r_level);

    logic out_free;
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_waveform    <= WAVE_SAW;
            r_start_phase <= '0;
            r_phase_step  <= '0;
            r_hold_length <= 16'd1;
            r_countdown   <= '0;
            r_held        <= '0;
            r_next        <= '0;
            r_diff        <= '0;
            r_noise       <= 32'd1;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_addr)
                    REG_WAVEFORM:    r_waveform    <= i_cfg_data[2:0];
                    REG_START_PHASE: r_start_phase <= i_cfg_data;
                    REG_PHASE_STEP:  r_phase_step  <= i_cfg_data;
                    REG_HOLD_LENGTH: r_hold_length <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_m_axis_tready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_pos <= i_s_axis_tdata;
                        case (r_waveform) inside
                            WAVE_SAW, WAVE_SINE, WAVE_SQUARE, WAVE_TRIANGLE: begin
                                r_state <= S_MUL;
                            end
                            WAVE_STEPPED: begin
                                if (r_countdown != '0) begin
                                    r_countdown <= n_countdown;
                                    r_level     <= r_held;
                                    r_state     <= S_FINISH;
                                end else begin
                                    r_countdown <= r_hold_length;
                                    r_cnt       <= '0;
                                    r_state     <= S_DRAW;
                                end
                            end
                            WAVE_SMOOTH: begin
                                if (r_countdown == '0) begin
                                    r_countdown <= r_hold_length;
                                    r_held      <= r_next;
                                    r_level     <= r_next;
                                    r_cnt       <= '0;
                                    r_state     <= S_DRAW;
                                end else begin
                                    r_countdown <= n_countdown;
                                    if (r_hold_length == '0) begin
                                        // full difference, clamped in the fade step
                                        r_quot  <= DW'(abs_diff);
                                        r_state <= S_FADE;
                                    end else begin
                                        r_num   <= (n_countdown > r_hold_length) ? '0
                                                   : r_hold_length - n_countdown;
                                        r_state <= S_FMUL;
                                    end
                                end
                            end
                            default: begin
                                r_level <= '0;
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_p[31:0];
                    r_state <= S_PHASE;
                end
                S_PHASE: begin
                    r_phase <= r_start_phase + r_prod;
                    r_state <= S_ROM;
                end
                S_ROM: begin
                    r_sine  <= w_sine_rom[rom_addr];
                    r_state <= S_SHAPE;
                end
                S_SHAPE: begin
                    r_level <= shape_level;
                    r_state <= S_FINISH;
                end
                S_DRAW: begin
                    r_noise <= n_noise;
                    r_cnt   <= r_cnt + CW'(1);
                    if (r_cnt == CW'(L - 1)) begin
                        if (r_waveform == WAVE_STEPPED) begin
                            r_held  <= n_noise[31 -: L];
                            r_level <= n_noise[31 -: L];
                        end else begin
                            r_next <= n_noise[31 -: L];
                            r_diff <= $signed({1'b0, n_noise[31 -: L]}) - $signed({1'b0, r_held});
                        end
                        r_state <= S_FINISH;
                    end
                end
                S_FMUL: begin
                    r_quot  <= mul_p[DW-1:0];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= rem_ge ? (rem_sh - {1'b0, r_hold_length}) : rem_sh;
                    r_quot <= {r_quot[DW-2:0], rem_ge};
                    r_cnt  <= r_cnt + CW'(1);
                    if (r_cnt == CW'(DW - 1)) begin
                        r_state <= S_FADE;
                    end
                end
                S_FADE: begin
                    r_level <= fade_level;
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= level_ext[15:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    `MWLFO_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n,
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state != S_IDLE), "accept did not start work")
    `MWLFO_NEVER(a_lfsr_not_zero, i_clk, i_rst_n, r_noise == 32'd0, "LFSR locked at zero")
    `MWLFO_ASSERT(a_finish_waits, i_clk, i_rst_n,
        (r_state == S_FINISH && r_out_valid && !i_m_axis_tready) |=> (r_state == S_FINISH),
        "result overwrote a pending beat")
    `MWLFO_ASSERT(a_fade_bounded, i_clk, i_rst_n,
        (r_state == S_FADE) |-> (r_quot <= DW'(abs_diff)), "fade step exceeds difference")

endmodule

/* verif/lfo_level_checker.sv */
// Checker for the multi-waveform LFO: level prediction and in-order comparison.
`timescale 1ns / 1ps

module lfo_level_checker
    import mwlfo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pos_valid,
    input  logic        i_pos_ready,
    input  logic [31:0] i_pos_data,
    input  logic        i_lvl_valid,
    input  logic        i_lvl_ready,
    input  logic [15:0] i_lvl_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam int TBL_BITS = 10;
    localparam int LVL_BITS = 16;
    localparam int TBL_N    = 1 << TBL_BITS;
    localparam logic [15:0] LVL_MAX = 16'hFFFF;

    logic [30:0] quarter_wave [0:TBL_N];

    t_wave       wave_sel;
    logic [31:0] phase_start;
    logic [31:0] phase_inc;
    logic [15:0] hold_len;

    logic [15:0]        countdown;
    logic [15:0]        held_lvl;
    logic [15:0]        next_lvl;
    logic signed [16:0] lvl_diff;
    logic [31:0]        lfsr;

    logic [15:0] expected_levels [$];
    int errors;
    int checked;

    // Taylor series of sin(x) to x^11 in Q2.30, evaluated Horner style.
    function automatic logic [30:0] quarter_sine_q30(int unsigned i);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned quot;
        longint unsigned s;
        ang = (longint'(i) * HALF_PI_Q30) >> TBL_BITS;
        ang_sq = (ang * ang) >> 30;
        term = Q30_ONE;
        for (int k = 0; k < 5; k++) begin
            quot = ((ang_sq * term) >> 30) / longint'((11 - 2 * k) * (10 - 2 * k));
            term = (quot >= Q30_ONE) ? 64'd0 : Q30_ONE - quot;
        end
        s = (ang * term) >> 30;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        return s[30:0];
    endfunction

    initial begin
        for (int i = 0; i <= TBL_N; i++) begin
            quarter_wave[i] = quarter_sine_q30(i);
        end
    end

    task automatic draw_noise(output logic [15:0] v);
        for (int k = 0; k < LVL_BITS; k++) begin
            lfsr = {lfsr[30:0], lfsr[31] ^ lfsr[21] ^ lfsr[1] ^ lfsr[0]};
        end
        v = lfsr[31:32-LVL_BITS];
    endtask

    task automatic smooth_level(output logic [15:0] lvl);
        longint hv;
        longint dv;
        longint mag;
        longint num;
        longint lv;
        if (countdown == 16'd0) begin
            countdown = hold_len;
            held_lvl = next_lvl;
            draw_noise(next_lvl);
            hv = held_lvl;
            dv = next_lvl;
            lvl_diff = 17'(dv - hv);
            lvl = held_lvl;
        end else begin
            countdown = countdown - 16'd1;
            hv = held_lvl;
            dv = lvl_diff;
            if (hold_len == 16'd0) begin
                lv = hv + dv;
            end else begin
                num = (countdown > hold_len) ? 0 : longint'(hold_len) - longint'(countdown);
                mag = ((dv < 0 ? -dv : dv) * num) / longint'(hold_len);
                lv = (dv < 0) ? hv - mag : hv + mag;
            end
            if (lv < 0) begin
                lv = 0;
            end
            lvl = (lv > longint'(LVL_MAX)) ? LVL_MAX : lv[15:0];
        end
    endtask

    task automatic predict_level(input logic [31:0] pos, output logic [15:0] lvl);
        logic [31:0]     ph;
        logic [9:0]      idx;
        longint unsigned mag;
        longint unsigned v;
        ph = phase_start + pos * phase_inc;
        lvl = 16'd0;
        case (wave_sel)
            WAVE_SAW: begin
                lvl = ph[31:16];
            end
            WAVE_SINE: begin
                idx = ph[29:20];
                mag = ph[30] ? quarter_wave[TBL_N - idx] : quarter_wave[idx];
                v = ph[31] ? Q30_ONE - mag : Q30_ONE + mag;
                v = v >> (31 - LVL_BITS);
                lvl = (v > LVL_MAX) ? LVL_MAX : v[15:0];
            end
            WAVE_SQUARE: begin
                lvl = ph[31] ? LVL_MAX : 16'd0;
            end
            WAVE_TRIANGLE: begin
                v = ph[31] ? (64'd1 << 32) - ph : ph;
                v = v >> (31 - LVL_BITS);
                lvl = (v > LVL_MAX) ? LVL_MAX : v[15:0];
            end
            WAVE_STEPPED: begin
                if (countdown != 16'd0) begin
                    countdown = countdown - 16'd1;
                end else begin
                    countdown = hold_len;
                    draw_noise(held_lvl);
                end
                lvl = held_lvl;
            end
            WAVE_SMOOTH: begin
                smooth_level(lvl);
            end
            default: begin
                lvl = 16'd0;
            end
        endcase
    endtask

    task automatic note_error(string what, logic [15:0] want, logic [15:0] got);
        errors++;
        if (errors <= 10) begin
            $display("%0t: %s at level beat %0d: expected %h, got %h",
                     $realtime, what, checked, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic [15:0] lvl;
        logic [15:0] want;
        if (!i_rst_n) begin
            wave_sel    = WAVE_SAW;
            phase_start = 32'd0;
            phase_inc   = 32'd0;
            hold_len    = 16'd1;
            countdown   = 16'd0;
            held_lvl    = 16'd0;
            next_lvl    = 16'd0;
            lvl_diff    = 17'sd0;
            lfsr        = 32'd1;
            expected_levels.delete();
        end else begin
            if (i_lvl_valid && i_lvl_ready) begin
                if (expected_levels.size() == 0) begin
                    note_error("level beat with nothing expected", 16'd0, i_lvl_data);
                end else begin
                    want = expected_levels.pop_front();
                    if (i_lvl_data !== want) begin
                        note_error("level mismatch", want, i_lvl_data);
                    end
                    checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    REG_WAVEFORM:    wave_sel    = i_cfg_data[2:0];
                    REG_START_PHASE: phase_start = i_cfg_data;
                    REG_PHASE_STEP:  phase_inc   = i_cfg_data;
                    REG_HOLD_LENGTH: hold_len    = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_pos_valid && i_pos_ready) begin
                predict_level(i_pos_data, lvl);
                expected_levels.push_back(lvl);
            end
        end
        o_fail_count <= errors;
        o_pending    <= expected_levels.size();
        o_checked    <= checked;
    end

endmodule

/* verif/multi_waveform_lfo_tb.sv */
// Testbench top for the multi-waveform LFO: reset, register setup, stimulus, verdict.
`timescale 1ns / 1ps

module multi_waveform_lfo_tb;
    import mwlfo_pkg::*;

    localparam t_wave WAVE_SPARE_A = 3'd6;
    localparam t_wave WAVE_SPARE_B = 3'd7;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 24;
    localparam int PHASE_ITEMS  = 75;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = 32'd0;   // [31:0] position
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;           // [15:0] level
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_addr = REG_WAVEFORM;
    logic [31:0] i_cfg_data = 32'd0;

    int fail_count;
    int pending;
    int checked;
    int idle_pct = 0;
    int stall_pct = 0;
    int positions_sent = 0;
    int reg_writes = 0;
    int cycle_count = 0;

    multi_waveform_lfo uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    lfo_level_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pos_valid  (i_s_axis_tvalid),
        .i_pos_ready  (o_s_axis_tready),
        .i_pos_data   (i_s_axis_tdata),
        .i_lvl_valid  (o_m_axis_tvalid),
        .i_lvl_ready  (i_m_axis_tready),
        .i_lvl_data   (o_m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d levels outstanding", cycle_count, pending);
            $display("FAIL");
            $finish;
        end
    end

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 73; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 24; stall_pct = 24; end
        endcase
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        reg_writes++;
    endtask

    // Registers change only once every level in flight has been taken.
    task automatic configure(t_wave w, logic [31:0] st, logic [31:0] inc, logic [15:0] hold);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(REG_WAVEFORM, 32'(w));
        write_reg(REG_START_PHASE, st);
        write_reg(REG_PHASE_STEP, inc);
        write_reg(REG_HOLD_LENGTH, 32'(hold));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_position(logic [31:0] pos);
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pos;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        positions_sent++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(65535, 1);
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] seq_pos;
        logic [31:0] pos;
        t_wave       w;
        logic [15:0] hold;
        int          r;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idling(0);

        // register defaults straight out of reset
        send_position(32'd0);
        send_position(32'hFFFF_FFFF);

        // saw wrapping around the cycle
        configure(WAVE_SAW, 32'hFFFF_FFFF, 32'd1, 16'd1);
        send_position(32'd0);
        send_position(32'd1);
        send_position(32'hFFFF_FFFF);

        // sine at the quadrant boundaries
        configure(WAVE_SINE, 32'd0, 32'h4000_0000, 16'd1);
        for (int i = 0; i < 5; i++) begin
            send_position(i);
        end

        // square on either side of the half cycle
        configure(WAVE_SQUARE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd1);
        send_position(32'd0);
        send_position(32'hFFFF_FFFF);

        // triangle peak saturation, just below the peak, and zero
        configure(WAVE_TRIANGLE, 32'h8000_0000, 32'hFFFF_FFFF, 16'd1);
        send_position(32'd0);
        send_position(32'd1);
        send_position(32'h8000_0000);

        configure(WAVE_SPARE_A, 32'h1234_5678, 32'h0000_0100, 16'd1);
        send_position(32'd7);
        configure(WAVE_SPARE_B, 32'h1234_5678, 32'h0000_0100, 16'd1);
        send_position(32'd7);

        // stepped: zero hold draws on every beat, then the longest hold
        configure(WAVE_STEPPED, 32'd0, 32'd0, 16'd0);
        send_position(32'd0);
        send_position(32'd1);
        configure(WAVE_STEPPED, 32'd0, 32'd0, 16'hFFFF);
        send_position(32'd2);
        send_position(32'd3);

        // smooth: new pair, hold cut below the countdown, then zero hold
        configure(WAVE_SMOOTH, 32'd0, 32'd0, 16'd3);
        send_position(32'd0);
        configure(WAVE_SMOOTH, 32'd0, 32'd0, 16'd1);
        send_position(32'd1);
        configure(WAVE_SMOOTH, 32'd0, 32'd0, 16'd0);
        for (int i = 0; i < 4; i++) begin
            send_position(i);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            r = $urandom_range(13);
            w = (r < 12) ? t_wave'(r % 6) : t_wave'(6 + r - 12);
            case ($urandom_range(9))
                0:       hold = 16'd0;
                1:       hold = 16'hFFFF;
                2:       hold = 16'($urandom);
                default: hold = 16'($urandom_range(12, 1));
            endcase
            configure(w, pick_word(), pick_word(), hold);
            set_idling(ph);
            seq_pos = $urandom;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(2) == 0) begin
                    pos = $urandom;
                end else begin
                    pos = seq_pos;
                    seq_pos = seq_pos + 32'd1;
                end
                send_position(pos);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d positions over %0d register writes, %0d levels checked.",
                 positions_sent, reg_writes, checked);
        $display("Covered all six shapes, spare shape codes and four idle/stall mixes.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("%0d errors, %0d levels outstanding", fail_count, pending);
            $display("FAIL");
        end
        $finish;
    end

endmodule
